FILE: sv/bpc_pkg.sv
package bpc_pkg;

   localparam int unsigned TICK_W     = 16;
   localparam int unsigned ELAPSED_W  = 17;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [TICK_W-1:0]    LONG_PRESS_RESET    = 16'd1000;
   localparam logic [TICK_W-1:0]    SHORT_IGNORE_RESET  = 16'd0;
   localparam logic [TICK_W-1:0]    AFTER_IGNORE_RESET  = 16'd0;
   localparam logic                 PRESSED_HIGH_RESET  = 1'b1;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX         = {ELAPSED_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_PRESS   = 2'd0,
      CSR_SHORT_IGNORE = 2'd1,
      CSR_AFTER_IGNORE = 2'd2,
      CSR_PRESSED_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [5:0] {
      MODE_RELEASED         = 6'b000001,
      MODE_PREPRESSED       = 6'b000010,
      MODE_PRESSED          = 6'b000100,
      MODE_LONG_REPORTED    = 6'b001000,
      MODE_AFTER_RELEASE    = 6'b010000,
      MODE_AFTER_REL_PRESS  = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [TICK_W-1:0] long_press_ticks;
      logic [TICK_W-1:0] short_press_ignore_ticks;
      logic [TICK_W-1:0] after_release_ignore_ticks;
      logic              pressed_level_high;
   } cfg_type;

   typedef struct packed {
      logic press_event;
      logic release_event;
      logic click_event;
      logic long_press_event;
   } flags_type;

endpackage

FILE: sv/bpc_channels_if.sv
interface bpc_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface bpc_rsp_if;
   logic valid;
   logic ready;
   logic press_event;
   logic release_event;
   logic click_event;
   logic long_press_event;

   modport source (output valid, output press_event, output release_event,
                   output click_event, output long_press_event, input ready);
   modport sink   (input valid, input press_event, input release_event,
                   input click_event, input long_press_event, output ready);
endinterface

FILE: sv/button_press_classifier.sv
// Button click / long-press classifier.
// req_chan carries one beat per millisecond tick with the raw pin level.
// rsp_chan returns exactly one beat per request beat, in order, with the
// press, release, click and long-press flags for that tick.
// csr_we/csr_index/csr_wdata write the four settings: long-press time,
// short-press ignore time, after-release ignore time and pin polarity.
// Write them only while no tick is in flight.
// Pipeline: input register, then the state update feeding the result
// register; a beat moves on from one to the next once the result register
// is empty or being read. Throughput is one beat per cycle while the
// receiver takes every beat; mode machine and tick counter step once per beat.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; req_chan.ready drops only when both
// are full. Reset (synchronous, active high) restores the default
// settings, the released mode, a zero tick count and a low previous level,
// and empties both pipeline registers.
module button_press_classifier (
   input  logic                            clock,
   input  logic                            reset,
   bpc_req_if.sink                         req_chan,
   bpc_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bpc_pkg::cfg_type   cfg;
   bpc_pkg::flags_type flags;

   logic               in_valid_ff, in_valid_in;
   logic               in_level_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bpc_pkg::flags_type rsp_flags_ff;
   logic               advance;
   logic               step;
   logic               req_take;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpc_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .level (in_level_ff),
      .cfg   (cfg),
      .flags (flags)
   );

   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)  in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_level_ff  <= req_chan.pin_level;
      if (step)     rsp_flags_ff <= flags;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.press_event      = rsp_flags_ff.press_event;
   assign rsp_chan.release_event    = rsp_flags_ff.release_event;
   assign rsp_chan.click_event      = rsp_flags_ff.click_event;
   assign rsp_chan.long_press_event = rsp_flags_ff.long_press_event;

endmodule

FILE: sv/bpc_csr.sv
module bpc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output bpc_pkg::cfg_type                 cfg
);

   bpc_pkg::cfg_type cfg_ff;
   bpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (bpc_pkg::csr_index_type'(csr_index))
            bpc_pkg::CSR_LONG_PRESS:   cfg_in.long_press_ticks = csr_wdata;
            bpc_pkg::CSR_SHORT_IGNORE: cfg_in.short_press_ignore_ticks = csr_wdata;
            bpc_pkg::CSR_AFTER_IGNORE: cfg_in.after_release_ignore_ticks = csr_wdata;
            bpc_pkg::CSR_PRESSED_HIGH: cfg_in.pressed_level_high = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks           <= bpc_pkg::LONG_PRESS_RESET;
         cfg_ff.short_press_ignore_ticks   <= bpc_pkg::SHORT_IGNORE_RESET;
         cfg_ff.after_release_ignore_ticks <= bpc_pkg::AFTER_IGNORE_RESET;
         cfg_ff.pressed_level_high         <= bpc_pkg::PRESSED_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/bpc_core.sv
module bpc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 level,
   input  bpc_pkg::cfg_type     cfg,
   output bpc_pkg::flags_type   flags
);

   bpc_pkg::mode_type                   mode_ff, mode_in;
   logic [bpc_pkg::ELAPSED_W-1:0]       elapsed_ff, elapsed_in;
   logic                                prev_ff, prev_in;
   logic [bpc_pkg::ELAPSED_W-1:0]       elapsed_inc;

   always_comb begin
      elapsed_inc = (elapsed_ff == bpc_pkg::ELAPSED_MAX) ? elapsed_ff
                                                         : elapsed_ff + 1'b1;
      mode_in    = mode_ff;
      elapsed_in = elapsed_inc;
      prev_in    = prev_ff;
      flags      = '0;

      // level change first
      if (level != prev_ff) begin
         prev_in = level;
         if (level == cfg.pressed_level_high) begin
            case (mode_ff)
               bpc_pkg::MODE_RELEASED: begin
                  elapsed_in = '0;
                  if (cfg.short_press_ignore_ticks == '0) begin
                     mode_in = bpc_pkg::MODE_PRESSED;
                     flags.press_event = 1'b1;
                  end else begin
                     mode_in = bpc_pkg::MODE_PREPRESSED;
                  end
               end
               bpc_pkg::MODE_AFTER_RELEASE: mode_in = bpc_pkg::MODE_AFTER_REL_PRESS;
               default: mode_in = mode_ff;
            endcase
         end else begin
            case (mode_ff)
               bpc_pkg::MODE_PREPRESSED: mode_in = bpc_pkg::MODE_RELEASED;
               bpc_pkg::MODE_PRESSED: begin
                  flags.release_event = 1'b1;
                  flags.click_event   = 1'b1;
                  mode_in    = bpc_pkg::MODE_AFTER_RELEASE;
                  elapsed_in = '0;
               end
               bpc_pkg::MODE_LONG_REPORTED: begin
                  flags.release_event = 1'b1;
                  mode_in    = bpc_pkg::MODE_AFTER_RELEASE;
                  elapsed_in = '0;
               end
               bpc_pkg::MODE_AFTER_REL_PRESS: mode_in = bpc_pkg::MODE_AFTER_RELEASE;
               default: mode_in = mode_ff;
            endcase
         end
      end

      // then one timeout check on the updated mode
      case (mode_in)
         bpc_pkg::MODE_PRESSED: begin
            if (elapsed_in > {1'b0, cfg.long_press_ticks}) begin
               mode_in = bpc_pkg::MODE_LONG_REPORTED;
               flags.long_press_event = 1'b1;
            end
         end
         bpc_pkg::MODE_PREPRESSED: begin
            if (elapsed_in > {1'b0, cfg.short_press_ignore_ticks}) begin
               mode_in = bpc_pkg::MODE_PRESSED;
               flags.press_event = 1'b1;
            end
         end
         bpc_pkg::MODE_AFTER_RELEASE: begin
            if (elapsed_in > {1'b0, cfg.after_release_ignore_ticks}) begin
               mode_in = bpc_pkg::MODE_RELEASED;
            end
         end
         default: mode_in = mode_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= bpc_pkg::MODE_RELEASED;
         elapsed_ff <= '0;
         prev_ff    <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         prev_ff    <= prev_in;
      end
   end

endmodule
